FILE: src/dcc_accessory_packet_decoder_assert.svh
`ifndef DCC_ACCESSORY_PACKET_DECODER_ASSERT_SVH
`define DCC_ACCESSORY_PACKET_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DCC_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DCC_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dccad_pkg.sv
package dccad_pkg;

    typedef enum logic [1:0] {
        VERDICT_IGNORE  = 2'd0,
        VERDICT_FOREIGN = 2'd1,
        VERDICT_OWN     = 2'd2,
        VERDICT_POM     = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        MODE_STANDARD    = 2'd0,
        MODE_COMPENSATED = 2'd1,
        MODE_NO_OFFSET   = 2'd2
    } t_station_mode;

    localparam logic [1:0] CFG_STATION_MODE  = 2'd0;
    localparam logic [1:0] CFG_FIRST_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_LAST_ADDRESS  = 2'd2;

    localparam logic [2:0] LEN_BASIC    = 3'd3;
    localparam logic [2:0] LEN_EXTENDED = 3'd4;
    localparam logic [2:0] LEN_POM      = 3'd6;

    localparam logic [15:0] COMP_OFFSET    = 16'd64;
    localparam logic [15:0] BROADCAST_ADDR = 16'd2047;
    localparam logic [15:0] NO_ADDRESS     = 16'hFFFF;
    localparam logic [7:0]  POM_MASK       = 8'hF0;
    localparam logic [7:0]  POM_PATTERN    = 8'hE0;
    localparam logic [7:0]  SECOND_RESET   = 8'h00;
    localparam logic [7:0]  THIRD_RESET    = 8'hFF;

    typedef struct packed {
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [2:0] packet_length;
    } t_dcc_in;

    typedef struct packed {
        t_verdict    verdict;
        logic [15:0] decoder_address;
        logic [15:0] output_address;
        logic [2:0]  turnout_number;
        logic        switch_position;
        logic [2:0]  device_number;
        logic        activate_flag;
        logic        is_basic;
        logic [7:0]  signal_aspect;
    } t_dcc_out;

endpackage

FILE: src/dcc_accessory_packet_decoder.sv
// Accessory packet decoder.
// Input channel (i_in_valid / o_in_ready) takes one framed accessory packet
// request: its first three bytes and its length. Output channel
// (o_out_valid / i_out_ready) returns exactly one result per request: the
// verdict, the decoder address and the decoded command fields.
// Config channel (i_cfg_valid / o_cfg_ready) writes station mode, first and
// last own address; it is always ready and should only be used while idle.
// A request passes the input register, then the decode into the result
// register, which drives o_out_valid.
// Throughput is one request per cycle while results are taken; the filter
// registers are read and updated in the same cycle as the decode.
// Reset (synchronous, active low) empties both stages, restores the config
// to standard mode with an own range of address 65535 only, and returns the
// filter history to its start values.
// When the receiver stalls the result register holds, the input register
// fills, and o_in_ready drops until the result is taken.
module dcc_accessory_packet_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dccad_pkg::t_dcc_in  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dccad_pkg::t_dcc_out o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import dccad_pkg::*;

    t_station_mode r_station_mode;
    logic [15:0]   r_first_address;
    logic [15:0]   r_last_address;

    logic          r_in_valid;
    t_dcc_in       r_in;
    logic          r_out_valid;
    t_dcc_out      r_out;

    logic [15:0]   r_last_foreign;
    logic [7:0]    r_last_second;
    logic [7:0]    r_last_third;

    logic [15:0]   n_last_foreign;
    logic [7:0]    n_last_second;
    logic [7:0]    n_last_third;
    t_dcc_out      n_out;

    logic          advance;
    logic          take;

    assign advance     = !r_out_valid || i_out_ready;
    assign take        = r_in_valid && advance;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] addr;
        logic [2:0]  turnout;
        logic        own;
        hi = {7'd0, ~r_in.byte_one[6:4], 6'd0};
        lo = {10'd0, r_in.byte_zero[5:0]};
        case (r_station_mode)
            MODE_NO_OFFSET: addr = hi + lo;
            MODE_COMPENSATED: begin
                // lsb of zero counts as 64, the top of the current group
                if (lo == 16'd0) begin
                    addr = hi + COMP_OFFSET - 16'd1;
                end else begin
                    addr = hi + lo - 16'd1;
                end
            end
            default: addr = hi + lo - 16'd1;
        endcase
        own = ((addr >= r_first_address) && (addr <= r_last_address))
              || (addr == BROADCAST_ADDR);
        turnout = {1'b0, r_in.byte_one[2:1]} + 3'd1;

        n_last_foreign = r_last_foreign;
        n_last_second  = r_last_second;
        n_last_third   = r_last_third;
        n_out = '0;
        n_out.verdict = VERDICT_IGNORE;
        n_out.decoder_address = addr;

        if (!own) begin
            if (addr != r_last_foreign) begin
                n_last_foreign = addr;
                n_out.verdict  = VERDICT_FOREIGN;
            end
        end else begin
            n_out.output_address  = {addr[13:0], 2'b00} + {13'd0, turnout};
            n_out.turnout_number  = turnout;
            n_out.switch_position = r_in.byte_one[0];
            n_out.device_number   = r_in.byte_one[2:0];
            n_out.activate_flag   = r_in.byte_one[3];
            n_out.is_basic        = r_in.byte_one[7];
            case (r_in.packet_length)
                LEN_BASIC: begin
                    if (r_in.byte_one != r_last_second) begin
                        n_last_second = r_in.byte_one;
                        // extended with three bytes is ignored, though its byte is still recorded
                        if (r_in.byte_one[7]) begin
                            n_out.verdict = VERDICT_OWN;
                        end
                    end
                end
                LEN_EXTENDED: begin
                    n_out.signal_aspect = r_in.byte_two;
                    if (!((r_in.byte_one == r_last_second)
                          && (r_in.byte_two == r_last_third))) begin
                        n_last_second = r_in.byte_one;
                        n_last_third  = r_in.byte_two;
                        n_out.verdict = VERDICT_OWN;
                    end
                end
                LEN_POM: begin
                    if ((r_in.byte_two & POM_MASK) == POM_PATTERN) begin
                        n_out.verdict = VERDICT_POM;
                    end
                end
                default: n_out.verdict = VERDICT_IGNORE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_mode  <= MODE_STANDARD;
            r_first_address <= NO_ADDRESS;
            r_last_address  <= NO_ADDRESS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STATION_MODE:  r_station_mode  <= t_station_mode'(i_cfg_data[1:0]);
                CFG_FIRST_ADDRESS: r_first_address <= i_cfg_data;
                CFG_LAST_ADDRESS:  r_last_address  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_last_foreign <= NO_ADDRESS;
            r_last_second  <= SECOND_RESET;
            r_last_third   <= THIRD_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (take) begin
                r_last_foreign <= n_last_foreign;
                r_last_second  <= n_last_second;
                r_last_third   <= n_last_third;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        if (take) begin
            r_out <= n_out;
        end
    end

`include "dcc_accessory_packet_decoder_assert.svh"

    `DCC_CHK_NEXT(a_history_holds_on_stall, r_out_valid && !i_out_ready,
        $stable(r_last_foreign) && $stable(r_last_second) && $stable(r_last_third),
        "filter history changed while the result was stalled")

    `DCC_CHK_NEXT(a_foreign_recorded, take && (n_out.verdict == VERDICT_FOREIGN),
        r_last_foreign == o_out.decoder_address,
        "reported foreign address was not recorded")

    `DCC_CHK_NOW(a_foreign_fields_clear,
        o_out_valid && (o_out.verdict == VERDICT_FOREIGN),
        (o_out.output_address == 16'd0) && (o_out.turnout_number == 3'd0)
            && (o_out.signal_aspect == 8'd0),
        "foreign result carries decoded command fields")

endmodule
